// File: src/mfd_pkg.sv
`timescale 1ns / 1ps

package mfd_pkg;

  localparam int FRAME_W   = 56;
  localparam int COUNT_W   = 16;
  localparam int SINGLE_W  = 28;
  localparam int SPEED_W   = 35;
  localparam int CURRENT_W = 32;
  localparam int CUR_ACC_W = 33;
  localparam int TEMP_W    = 8;
  localparam int TURNS_W   = 24;
  localparam int TOTAL_W   = 49;
  localparam int COEF_W    = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [COEF_W-1:0] Q16_ONE = 17'h10000;
  localparam logic signed [COUNT_W:0] HALF_TURN = 17'sd4096;
  localparam logic [11:0] COUNT_TO_Q16_DEG = 12'd2880;
  // One turn is 360 * 65536 = 45 * 2^19 in Q16 degrees.
  localparam logic signed [6:0] TURN_DEG_MULT = 7'sd45;
  localparam int TURN_DEG_SHIFT = 19;
  localparam logic signed [TURNS_W-1:0] TURNS_MAX = 24'sh7FFFFF;
  localparam logic signed [TURNS_W-1:0] TURNS_MIN = 24'sh800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_COEF   = 2'd0,
    REG_CURRENT_COEF = 2'd1
  } cfg_reg_t;

endpackage

// File: src/mfd_if.sv
`timescale 1ns / 1ps

interface mfd_frame_if;
  logic                              valid;
  logic                              ready;
  logic [mfd_pkg::FRAME_W-1:0]       frame_bytes;

  modport source (output valid, output frame_bytes, input ready);
  modport sink   (input valid, input frame_bytes, output ready);
endinterface

interface mfd_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [mfd_pkg::COUNT_W-1:0]          encoder_count;
  logic [mfd_pkg::SINGLE_W-1:0]         single_turn_angle;
  logic signed [mfd_pkg::SPEED_W-1:0]   speed_filtered;
  logic signed [mfd_pkg::CURRENT_W-1:0] current_filtered;
  logic [mfd_pkg::TEMP_W-1:0]           temperature;
  logic signed [mfd_pkg::TURNS_W-1:0]   turn_count;
  logic signed [mfd_pkg::TOTAL_W-1:0]   absolute_angle;

  modport source (output valid, output encoder_count, output single_turn_angle,
                  output speed_filtered, output current_filtered, output temperature,
                  output turn_count, output absolute_angle, input ready);
  modport sink   (input valid, input encoder_count, input single_turn_angle,
                  input speed_filtered, input current_filtered, input temperature,
                  input turn_count, input absolute_angle, output ready);
endinterface

interface mfd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mfd_pkg::CFG_IDX_W-1:0]     index;
  logic [mfd_pkg::COEF_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/motor_feedback_decoder.sv
`timescale 1ns / 1ps

// Decodes one 7-byte motor feedback frame per item arriving on frame_in and
// returns one result item on result_out: raw count, single-turn angle, smoothed
// speed and current, temperature, turn count and total angle.
// The cfg channel writes the two smoothing coefficients (index 0 speed,
// index 1 current); it is ready outside reset, and the user must write it while
// the block is idle; the block itself does not enforce this. A frame's result item
// is registered and appears in the cycle after acceptance. Throughput is one item
// per cycle while the receiver takes results, set by the single result register
// and the per-item filter and turn update. Outside reset, frame_in is ready
// whenever the result register is empty or is being taken in the same cycle, so a
// stalled receiver holds its result and stops intake after one item, and nothing
// is lost. Reset clears the turn counter, the previous count and both filter
// accumulators, and sets both coefficients to one (no smoothing).
module motor_feedback_decoder (
  input  logic               clk,
  input  logic               rst,
  mfd_frame_if.sink          frame_in,
  mfd_result_if.source       result_out,
  mfd_cfg_if.sink            cfg
);

  logic [mfd_pkg::COEF_W-1:0]             speed_coef;
  logic [mfd_pkg::COEF_W-1:0]             current_coef;
  logic [mfd_pkg::COUNT_W-1:0]            previous_count;
  logic signed [mfd_pkg::TURNS_W-1:0]     turns;
  logic signed [mfd_pkg::SPEED_W-1:0]     speed_accum;
  logic signed [mfd_pkg::CUR_ACC_W-1:0]   current_accum;
  logic                                   out_valid;

  logic                                   accept;
  logic [mfd_pkg::COUNT_W-1:0]            count;
  logic signed [15:0]                     rpm;
  logic signed [15:0]                     cur;
  logic [mfd_pkg::TEMP_W-1:0]             temp;

  logic [mfd_pkg::COEF_W-1:0]             speed_c;
  logic [mfd_pkg::COEF_W-1:0]             current_c;

  logic signed [18:0]                     rpm6;
  logic signed [35:0]                     speed_diff;
  logic signed [53:0]                     speed_prod;
  logic signed [53:0]                     speed_step;
  logic signed [mfd_pkg::SPEED_W-1:0]     speed_accum_next;

  logic signed [33:0]                     current_diff;
  logic signed [51:0]                     current_prod;
  logic signed [51:0]                     current_step;
  logic signed [mfd_pkg::CUR_ACC_W-1:0]   current_accum_next;

  logic signed [mfd_pkg::COUNT_W:0]       count_diff;
  logic signed [mfd_pkg::TURNS_W-1:0]     turns_next;
  logic [mfd_pkg::SINGLE_W-1:0]           single;
  logic signed [30:0]                     turn_deg;
  logic signed [mfd_pkg::TOTAL_W:0]       total;

  assign accept         = frame_in.valid && frame_in.ready;
  assign frame_in.ready = !rst && (!out_valid || result_out.ready);
  assign cfg.ready      = !rst;
  assign result_out.valid = out_valid;

  assign count = frame_in.frame_bytes[55:40];
  assign rpm   = frame_in.frame_bytes[39:24];
  assign cur   = frame_in.frame_bytes[23:8];
  assign temp  = frame_in.frame_bytes[7:0];

  // A coefficient above one is used as one.
  assign speed_c   = speed_coef[16]   ? mfd_pkg::Q16_ONE : speed_coef;
  assign current_c = current_coef[16] ? mfd_pkg::Q16_ONE : current_coef;

  // acc' = acc + round(c * (sample - acc) / 2^16), which equals the convex
  // blend of old and new with rounding half upwards.
  assign rpm6 = $signed({{3{rpm[15]}}, rpm}) * 19'sd6;
  assign speed_diff = $signed({rpm6[18], rpm6, 16'b0})
                    - $signed({speed_accum[mfd_pkg::SPEED_W-1], speed_accum});
  assign speed_prod = $signed({1'b0, speed_c}) * speed_diff;
  assign speed_step = (speed_prod + 54'sd32768) >>> 16;
  assign speed_accum_next = speed_accum + speed_step[mfd_pkg::SPEED_W-1:0];

  assign current_diff = $signed({{2{cur[15]}}, cur, 16'b0})
                      - $signed({current_accum[mfd_pkg::CUR_ACC_W-1], current_accum});
  assign current_prod = $signed({1'b0, current_c}) * current_diff;
  assign current_step = (current_prod + 52'sd32768) >>> 16;
  assign current_accum_next = current_accum + current_step[mfd_pkg::CUR_ACC_W-1:0];

  // A backward wrap moves the count up by more than half a turn.
  assign count_diff = $signed({1'b0, count}) - $signed({1'b0, previous_count});

  always_comb begin
    turns_next = turns;
    if (count_diff > mfd_pkg::HALF_TURN) begin
      if (turns != mfd_pkg::TURNS_MIN) begin
        turns_next = turns - 24'sd1;
      end
    end else if (count_diff < -mfd_pkg::HALF_TURN) begin
      if (turns != mfd_pkg::TURNS_MAX) begin
        turns_next = turns + 24'sd1;
      end
    end
  end

  assign single   = mfd_pkg::SINGLE_W'(count * mfd_pkg::COUNT_TO_Q16_DEG);
  assign turn_deg = turns_next * mfd_pkg::TURN_DEG_MULT;
  assign total    = ($signed({turn_deg[30], turn_deg}) <<< mfd_pkg::TURN_DEG_SHIFT)
                  + $signed({22'b0, single});

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_coef     <= mfd_pkg::Q16_ONE;
      current_coef   <= mfd_pkg::Q16_ONE;
      previous_count <= '0;
      turns          <= '0;
      speed_accum    <= '0;
      current_accum  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          mfd_pkg::REG_SPEED_COEF:   speed_coef   <= cfg.data;
          mfd_pkg::REG_CURRENT_COEF: current_coef <= cfg.data;
          default: ;
        endcase
      end
      if (accept) begin
        previous_count <= count;
        turns          <= turns_next;
        speed_accum    <= speed_accum_next;
        current_accum  <= current_accum_next;
        out_valid      <= 1'b1;
      end else if (result_out.ready) begin
        out_valid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_out.encoder_count     <= count;
      result_out.single_turn_angle <= single;
      result_out.speed_filtered    <= speed_accum_next;
      result_out.current_filtered  <= current_accum_next[mfd_pkg::CURRENT_W-1:0];
      result_out.temperature       <= temp;
      result_out.turn_count        <= turns_next;
      result_out.absolute_angle    <= total[mfd_pkg::TOTAL_W-1:0];
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [mfd_pkg::COUNT_W-1:0]   encoder_count;
    logic [mfd_pkg::SINGLE_W-1:0]  single_turn_angle;
    logic [mfd_pkg::SPEED_W-1:0]   speed_filtered;
    logic [mfd_pkg::CURRENT_W-1:0] current_filtered;
    logic [mfd_pkg::TEMP_W-1:0]    temperature;
    logic [mfd_pkg::TURNS_W-1:0]   turn_count;
    logic [mfd_pkg::TOTAL_W-1:0]   absolute_angle;
  } feedback_t;

  localparam logic [mfd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int     HALF          = mfd_pkg::HALF_TURN;
  localparam int     TURN_LO       = mfd_pkg::TURNS_MIN;
  localparam int     TURN_HI       = mfd_pkg::TURNS_MAX;
  localparam longint TURN_Q16      = 360 * 65536;
  localparam int     PHASES        = 6;
  localparam int     HALF_PHASE    = 45;
  localparam int     LONG_HOLD     = 250;

  logic clk = 1'b0;
  logic rst;

  mfd_frame_if  frame_bus ();
  mfd_result_if result_bus ();
  mfd_cfg_if    cfg_bus ();

  motor_feedback_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_bus),
    .result_out (result_bus),
    .cfg        (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("FAIL motor_feedback_decoder");
    $finish;
  end

  // Shadow copy of the block's state and coefficients.
  logic [mfd_pkg::COUNT_W-1:0] last_count   = '0;
  int                          turn_total   = 0;
  longint                      speed_q16    = 0;
  longint                      current_q16  = 0;
  logic [mfd_pkg::COEF_W-1:0]  speed_coef   = mfd_pkg::Q16_ONE;
  logic [mfd_pkg::COEF_W-1:0]  current_coef = mfd_pkg::Q16_ONE;

  logic [mfd_pkg::FRAME_W-1:0] frame_queue[$];
  feedback_t                   expected_feedback[$];

  int burst_left;
  int gap_left;
  int hold_left;
  int stall_mode;
  int cycle_no;
  int results_seen;
  int fail_count = 0;
  int rotor = 0;

  function automatic longint smooth_q16(input longint acc, input longint sample,
                                        input logic [mfd_pkg::COEF_W-1:0] coef);
    longint w;
    longint mix;
    w = (coef > mfd_pkg::Q16_ONE) ? longint'(mfd_pkg::Q16_ONE) : longint'(coef);
    mix = (65536 - w) * acc + w * sample;
    // Adding a half and shifting arithmetically rounds half toward plus infinity.
    return (mix + 32768) >>> 16;
  endfunction

  function automatic feedback_t decode_feedback(input logic [mfd_pkg::FRAME_W-1:0] f);
    logic [mfd_pkg::COUNT_W-1:0] count;
    logic signed [15:0]          rpm;
    logic signed [15:0]          cur;
    int                          diff;
    longint                      single;
    longint                      total;
    feedback_t                   r;
    count = f[55:40];
    rpm   = f[39:24];
    cur   = f[23:8];
    single = longint'(count) * 2880;
    speed_q16   = smooth_q16(speed_q16, longint'(rpm) * 6 * 65536, speed_coef);
    current_q16 = smooth_q16(current_q16, longint'(cur) * 65536, current_coef);
    diff = int'(count) - int'(last_count);
    if (diff > HALF) begin
      if (turn_total > TURN_LO) turn_total--;
    end else if (diff < -HALF) begin
      if (turn_total < TURN_HI) turn_total++;
    end
    last_count = count;
    total = longint'(turn_total) * TURN_Q16 + single;
    r.encoder_count     = count;
    r.single_turn_angle = mfd_pkg::SINGLE_W'(single);
    r.speed_filtered    = mfd_pkg::SPEED_W'(speed_q16);
    r.current_filtered  = mfd_pkg::CURRENT_W'(current_q16);
    r.temperature       = f[7:0];
    r.turn_count        = mfd_pkg::TURNS_W'(turn_total);
    r.absolute_angle    = mfd_pkg::TOTAL_W'(total);
    return r;
  endfunction

  // Frame driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      frame_bus.valid <= 1'b0;
      burst_left = 20;
      gap_left   = 0;
    end else begin
      if (frame_bus.valid && frame_bus.ready) begin
        expected_feedback.push_back(decode_feedback(frame_bus.frame_bytes));
        void'(frame_queue.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!frame_bus.valid || frame_bus.ready) begin
        if (gap_left > 0 || frame_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          frame_bus.valid <= 1'b0;
        end else begin
          frame_bus.valid       <= 1'b1;
          frame_bus.frame_bytes <= frame_queue[0];
        end
      end
    end
  end

  // Result monitor with its own stall pattern and occasional long hold-offs.
  always @(posedge clk) begin
    feedback_t got;
    feedback_t want;
    if (rst) begin
      result_bus.ready <= 1'b0;
      stall_mode   = 0;
      cycle_no     = 0;
      hold_left    = 0;
      results_seen = 0;
    end else begin
      cycle_no++;
      if (result_bus.valid && result_bus.ready) begin
        got = {result_bus.encoder_count, result_bus.single_turn_angle,
               result_bus.speed_filtered, result_bus.current_filtered,
               result_bus.temperature, result_bus.turn_count, result_bus.absolute_angle};
        if (expected_feedback.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result item at %0t: %p", $realtime, got);
        end else begin
          want = expected_feedback.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch at %0t (expected/actual):", $realtime);
              $display("  count %h/%h single %h/%h speed %h/%h",
                       want.encoder_count, got.encoder_count,
                       want.single_turn_angle, got.single_turn_angle,
                       want.speed_filtered, got.speed_filtered);
              $display("  current %h/%h temp %h/%h turns %h/%h total %h/%h",
                       want.current_filtered, got.current_filtered,
                       want.temperature, got.temperature,
                       want.turn_count, got.turn_count,
                       want.absolute_angle, got.absolute_angle);
            end
          end
        end
        results_seen++;
        // A long hold-off lets the block fill up and push back on the sender.
        if (results_seen % 150 == 0) hold_left = LONG_HOLD;
      end
      if (cycle_no % 48 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: result_bus.ready <= 1'b1;
          1: result_bus.ready <= 1'($urandom_range(0, 1));
          2: result_bus.ready <= (cycle_no % 4) != 3;
          default: result_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic write_coef(input logic [mfd_pkg::CFG_IDX_W-1:0] idx,
                            input logic [mfd_pkg::COEF_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == mfd_pkg::REG_SPEED_COEF) speed_coef = value;
    else if (idx == mfd_pkg::REG_CURRENT_COEF) current_coef = value;
  endtask

  // Waits until every queued frame has gone in and every result has come out.
  task automatic drain_pipeline();
    while (frame_queue.size() != 0 || expected_feedback.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [15:0] random_signed16();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly a rotor turning by plausible steps, with some near-half-turn
  // jumps and some counts that are pure noise over the whole 16-bit range.
  task automatic push_random(input int n);
    int                          sel;
    logic [mfd_pkg::COUNT_W-1:0] cnt;
    repeat (n) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        cnt = 16'($urandom);
      end else begin
        if (sel == 1)
          rotor = rotor + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(4090, 4102));
        else
          rotor = rotor + int'($urandom_range(0, 3000)) - 1500;
        rotor = rotor & 8191;
        cnt   = 16'(rotor);
      end
      frame_queue.push_back({cnt, random_signed16(), random_signed16(), 8'($urandom)});
    end
  endtask

  initial begin
    logic [mfd_pkg::COEF_W-1:0] speed_set   [PHASES];
    logic [mfd_pkg::COEF_W-1:0] current_set [PHASES];
    speed_set   = '{17'h10000, 17'h00000, 17'h00001, 17'h1FFFF, 17'h0FFFF, 17'h00000};
    current_set = '{17'h00000, 17'h10000, 17'h1FFFF, 17'h00001, 17'h08000, 17'h00000};
    rst                   = 1'b1;
    frame_bus.valid       = 1'b0;
    frame_bus.frame_bytes = '0;
    result_bus.ready      = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = '0;
    cfg_bus.data          = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The first frame above half a turn counts as a backward wrap.
    frame_queue.push_back({16'd4097, 16'h7FFF, 16'h7FFF, 8'hFF});
    // Jumps of exactly half a turn either way leave the turn count alone.
    frame_queue.push_back({16'd8193, 16'h8000, 16'h8000, 8'h00});
    frame_queue.push_back({16'd4097, 16'h0000, 16'h0000, 8'h5A});
    frame_queue.push_back({16'd0,    16'hFFFF, 16'h0001, 8'hA5});
    frame_queue.push_back({16'hFFFF, 16'h7FFF, 16'h7FFF, 8'hFF});
    frame_queue.push_back({16'd0,    16'h8000, 16'h8000, 8'h00});
    frame_queue.push_back({16'd8191, 16'h0001, 16'hFFFF, 8'h01});
    frame_queue.push_back({16'd0,    16'h0000, 16'h0000, 8'h80});
    frame_queue.push_back({16'd4096, 16'h1234, 16'hEDCB, 8'h7F});
    frame_queue.push_back({16'd0,    16'h7FFF, 16'h8000, 8'hFE});
    frame_queue.push_back({16'hAAAA, 16'hAAAA, 16'h5555, 8'hAA});
    frame_queue.push_back({16'h5555, 16'h5555, 16'hAAAA, 8'h55});
    frame_queue.push_back({16'd0,    16'h0000, 16'h0000, 8'h00});
    drain_pipeline();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        speed_set[p]   = mfd_pkg::COEF_W'($urandom_range(2, 65535));
        current_set[p] = mfd_pkg::COEF_W'($urandom_range(2, 65535));
      end
      write_coef(mfd_pkg::REG_SPEED_COEF, speed_set[p]);
      write_coef(mfd_pkg::REG_CURRENT_COEF, current_set[p]);
      // An index with no register behind it must change nothing.
      if (p == 2) write_coef(REG_UNMAPPED, 17'h00123);
      push_random(HALF_PHASE);
      drain_pipeline();
      push_random(HALF_PHASE);
      drain_pipeline();
    end

    if (fail_count == 0 && expected_feedback.size() == 0) begin
      $display("PASS motor_feedback_decoder");
    end else begin
      $display("FAIL motor_feedback_decoder");
    end
    $finish;
  end

endmodule

// File: files.f
src/mfd_pkg.sv
src/mfd_if.sv
src/motor_feedback_decoder.sv
verif/testbench.sv
